FILE: design/rfep_pkg.sv
`default_nettype none

package rfep_pkg;

    localparam int CH_ID_W     = 2;
    localparam int TIME_W      = 32;
    localparam int LEN_W       = 16;
    localparam int FILT_W      = 32;
    localparam int MASK_W      = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int Q_PTR_W     = 2;
    localparam int Q_CNT_W     = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE_MASK  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_START    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_START    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_PERIOD   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PERIOD   = 3'd4;

    localparam logic [MASK_W-1:0] RST_ENABLE_MASK = 3'd0;
    localparam logic [LEN_W-1:0]  RST_MIN_START   = 16'd1000;
    localparam logic [LEN_W-1:0]  RST_MAX_START   = 16'd20000;
    localparam logic [LEN_W-1:0]  RST_MIN_PERIOD  = 16'd400;
    localparam logic [LEN_W-1:0]  RST_MAX_PERIOD  = 16'd3600;

    localparam logic [CH_ID_W-1:0] CH_NO_MASK_BIT = 2'd3;

    typedef struct packed {
        logic [MASK_W-1:0] enable_mask;
        logic [LEN_W-1:0]  min_start;
        logic [LEN_W-1:0]  max_start;
        logic [LEN_W-1:0]  min_period;
        logic [LEN_W-1:0]  max_period;
    } cfg_t;

    typedef struct packed {
        logic [CH_ID_W-1:0] channel;
        logic [LEN_W-1:0]   length;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } push_t;

endpackage

`default_nettype wire

FILE: design/rfep_edge_if.sv
`default_nettype none

interface rfep_edge_if;
    logic                            valid;
    logic                            ready;
    logic [rfep_pkg::CH_ID_W-1:0]    channel_id;
    logic [rfep_pkg::TIME_W-1:0]     edge_time;
    logic                            line_level;

    modport source (output valid, output channel_id, output edge_time, output line_level,
                    input ready);
    modport sink (input valid, input channel_id, input edge_time, input line_level,
                  output ready);
endinterface

`default_nettype wire

FILE: design/rfep_pulse_if.sv
`default_nettype none

interface rfep_pulse_if;
    logic                            valid;
    logic                            ready;
    logic [rfep_pkg::CH_ID_W-1:0]    out_channel;
    logic [rfep_pkg::LEN_W-1:0]      pulse_length;
    logic                            last_of_run;

    modport source (output valid, output out_channel, output pulse_length,
                    output last_of_run, input ready);
    modport sink (input valid, input out_channel, input pulse_length, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

FILE: design/rf_edge_pulse_framer.sv
// channel   direction  transaction
// edges     in         channel_id, edge_time, line_level
// pulses    out        out_channel, pulse_length, last_of_run
// cfg       in         cfg_we, cfg_index, cfg_data (write only)
//
// one edge per cycle while room allows; an edge is evaluated from its input register
// results reach pulses through a four-entry result queue
// an edge giving a start marker and a pulse pushes two queue entries
// reset clears channel state and returns registers to their defaults
// a stall on pulses fills the queue until room drops, and then drops edges.ready
`default_nettype none

module rf_edge_pulse_framer #(
    parameter int CHANNELS = 3
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    rfep_edge_if.sink                                 edges,
    rfep_pulse_if.source                              pulses,
    input  wire logic                                 cfg_we,
    input  wire logic [rfep_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [rfep_pkg::CFG_DATA_W-1:0]      cfg_data
);

    rfep_pkg::cfg_t   cfg;
    rfep_pkg::push_t  push;
    logic             room;

    rfep_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rfep_chan_unit #(
        .CHANNELS (CHANNELS)
    ) u_chan (
        .clk   (clk),
        .rst_n (rst_n),
        .edges (edges),
        .cfg   (cfg),
        .room  (room),
        .push  (push)
    );

    rfep_result_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .pulses (pulses)
    );

endmodule

`default_nettype wire

FILE: design/rfep_cfg_regs.sv
`default_nettype none

module rfep_cfg_regs (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [rfep_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [rfep_pkg::CFG_DATA_W-1:0]      cfg_data,
    output rfep_pkg::cfg_t                            cfg
);

    rfep_pkg::cfg_t cfg_reg;
    rfep_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                rfep_pkg::REG_ENABLE_MASK:
                    cfg_next.enable_mask = cfg_data[rfep_pkg::MASK_W-1:0];
                rfep_pkg::REG_MIN_START:  cfg_next.min_start  = cfg_data;
                rfep_pkg::REG_MAX_START:  cfg_next.max_start  = cfg_data;
                rfep_pkg::REG_MIN_PERIOD: cfg_next.min_period = cfg_data;
                rfep_pkg::REG_MAX_PERIOD: cfg_next.max_period = cfg_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable_mask <= rfep_pkg::RST_ENABLE_MASK;
            cfg_reg.min_start   <= rfep_pkg::RST_MIN_START;
            cfg_reg.max_start   <= rfep_pkg::RST_MAX_START;
            cfg_reg.min_period  <= rfep_pkg::RST_MIN_PERIOD;
            cfg_reg.max_period  <= rfep_pkg::RST_MAX_PERIOD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: design/rfep_chan_unit.sv
`default_nettype none

module rfep_chan_unit #(
    parameter int CHANNELS = 3
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    rfep_edge_if.sink             edges,
    input  wire rfep_pkg::cfg_t   cfg,
    input  wire logic             room,
    output rfep_pkg::push_t       push
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic                             item_valid_reg;
    logic [rfep_pkg::CH_ID_W-1:0]     item_ch_reg;
    logic [rfep_pkg::TIME_W-1:0]      item_time_reg;
    logic                             item_level_reg;

    logic [rfep_pkg::TIME_W-1:0]      last_time_reg  [CHANNELS];
    logic                             level_reg      [CHANNELS];
    logic [rfep_pkg::FILT_W-1:0]      filt_reg       [CHANNELS];
    logic                             pending_reg    [CHANNELS];
    logic                             active_reg     [CHANNELS];

    logic [rfep_pkg::TIME_W-1:0]      last_time_next;
    logic                             level_next;
    logic [rfep_pkg::FILT_W-1:0]      filt_next;
    logic                             pending_next;
    logic                             active_next;

    logic                             accept;
    logic                             fire;
    logic                             ch_ok;
    logic                             en;
    logic [IDX_W-1:0]                 idx;
    logic [rfep_pkg::TIME_W-1:0]      cur_last;
    logic                             cur_level;
    logic [rfep_pkg::FILT_W-1:0]      cur_filt;
    logic                             cur_pending;
    logic                             cur_active;
    logic                             wrap;
    logic [rfep_pkg::LEN_W-1:0]       d_raw;
    logic [rfep_pkg::FILT_W-1:0]      f_sum;
    logic                             f_pos;
    logic                             spike;
    logic [rfep_pkg::LEN_W-1:0]       d_q;
    logic [1:0]                       n_res;
    logic [rfep_pkg::LEN_W-1:0]       len0;
    logic [rfep_pkg::LEN_W-1:0]       len1;

    assign accept      = edges.valid && edges.ready;
    assign fire        = item_valid_reg && room;
    assign edges.ready = !item_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_ch_reg    <= edges.channel_id;
            item_time_reg  <= edges.edge_time;
            item_level_reg <= edges.line_level;
        end
    end

    // channel 3 has no enable bit
    assign ch_ok = (item_ch_reg != rfep_pkg::CH_NO_MASK_BIT)
                   && (32'(item_ch_reg) < CHANNELS);
    assign en    = ch_ok && cfg.enable_mask[item_ch_reg];
    assign idx   = en ? IDX_W'(item_ch_reg) : '0;

    assign cur_last    = last_time_reg[idx];
    assign cur_level   = level_reg[idx];
    assign cur_filt    = filt_reg[idx];
    assign cur_pending = pending_reg[idx];
    assign cur_active  = active_reg[idx];

    assign wrap  = item_time_reg < cur_last;
    assign d_raw = item_time_reg[rfep_pkg::LEN_W-1:0] - cur_last[rfep_pkg::LEN_W-1:0];
    assign f_sum = cur_level ? (cur_filt + {16'd0, d_raw}) : (cur_filt - {16'd0, d_raw});
    assign f_pos = (f_sum != '0) && !f_sum[rfep_pkg::FILT_W-1];
    assign spike = f_pos && (f_sum < {16'd0, cfg.min_period});
    assign d_q   = cur_level ? f_sum[rfep_pkg::LEN_W-1:0]
                             : (cfg.min_period - f_sum[rfep_pkg::LEN_W-1:0]);

    always_comb
    begin
        last_time_next = cur_last;
        level_next     = cur_level;
        filt_next      = cur_filt;
        pending_next   = cur_pending;
        active_next    = cur_active;
        n_res          = 2'd0;
        len0           = '0;
        len1           = '0;
        if (en)
        begin
            level_next = item_level_reg;
            if (wrap)
            begin
                last_time_next = item_time_reg;
                active_next    = 1'b0;
            end
            else if (spike)
            begin
                filt_next    = f_sum;
                pending_next = 1'b1;
            end
            else
            begin
                filt_next = cur_level ? {16'd0, cfg.min_period} : '0;
                priority if (cur_pending)
                begin
                    pending_next = 1'b0;
                end
                else if (cur_active && (d_q > cfg.max_period))
                begin
                    // frame stop marker
                    active_next = 1'b0;
                    n_res       = 2'd1;
                end
                else if (d_q > cfg.max_start)
                begin
                    active_next = 1'b0;
                end
                else
                begin
                    last_time_next = item_time_reg;
                    if (!cur_active && (d_q > cfg.min_start) && (d_q < cfg.max_start))
                    begin
                        // frame start marker then the pulse
                        active_next = 1'b1;
                        n_res       = 2'd2;
                        len1        = d_q;
                    end
                    else
                    begin
                        n_res = 2'd1;
                        len0  = d_q;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                last_time_reg[i] <= '0;
                level_reg[i]     <= 1'b0;
                filt_reg[i]      <= '0;
                pending_reg[i]   <= 1'b0;
                active_reg[i]    <= 1'b0;
            end
        end
        else if (fire && en)
        begin
            last_time_reg[idx] <= last_time_next;
            level_reg[idx]     <= level_next;
            filt_reg[idx]      <= filt_next;
            pending_reg[idx]   <= pending_next;
            active_reg[idx]    <= active_next;
        end
    end

    assign push.count        = fire ? n_res : 2'd0;
    assign push.res0.channel = item_ch_reg;
    assign push.res0.length  = len0;
    assign push.res0.last    = (n_res == 2'd1);
    assign push.res1.channel = item_ch_reg;
    assign push.res1.length  = len1;
    assign push.res1.last    = 1'b1;

endmodule

`default_nettype wire

FILE: design/rfep_result_queue.sv
`default_nettype none

module rfep_result_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rfep_pkg::push_t   push,
    output logic                   room,
    rfep_pulse_if.source           pulses
);

    localparam int DEPTH = 2 ** rfep_pkg::Q_PTR_W;
    localparam logic [rfep_pkg::Q_CNT_W-1:0] Q_CNT_W_TWO = 3'd2;

    rfep_pkg::result_t                q_reg [DEPTH];
    logic [rfep_pkg::Q_PTR_W-1:0]     wr_ptr_reg;
    logic [rfep_pkg::Q_PTR_W-1:0]     wr_ptr_next;
    logic [rfep_pkg::Q_PTR_W-1:0]     rd_ptr_reg;
    logic [rfep_pkg::Q_PTR_W-1:0]     rd_ptr_next;
    logic [rfep_pkg::Q_CNT_W-1:0]     count_reg;
    logic [rfep_pkg::Q_CNT_W-1:0]     count_next;
    logic [rfep_pkg::Q_CNT_W-1:0]     count_after_pop;
    logic [rfep_pkg::Q_PTR_W-1:0]     wr_ptr_plus1;
    logic                             pop;

    assign pop             = pulses.valid && pulses.ready;
    assign count_after_pop = count_reg - {{(rfep_pkg::Q_CNT_W-1){1'b0}}, pop};
    // two free entries needed for the worst-case transaction
    assign room            = count_after_pop <= Q_CNT_W_TWO;
    assign count_next      = count_after_pop + {1'b0, push.count};
    assign wr_ptr_plus1    = wr_ptr_reg + {{(rfep_pkg::Q_PTR_W-1){1'b0}}, 1'b1};
    assign wr_ptr_next     = wr_ptr_reg + push.count;
    assign rd_ptr_next     = rd_ptr_reg + {{(rfep_pkg::Q_PTR_W-1){1'b0}}, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            q_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.count == 2'd2)
        begin
            q_reg[wr_ptr_plus1] <= push.res1;
        end
    end

    assign pulses.valid        = count_reg != '0;
    assign pulses.out_channel  = q_reg[rd_ptr_reg].channel;
    assign pulses.pulse_length = q_reg[rd_ptr_reg].length;
    assign pulses.last_of_run  = q_reg[rd_ptr_reg].last;

endmodule

`default_nettype wire

FILE: tb/sv/rf_edge_pulse_framer_tb.sv
`timescale 1ns / 100ps

module rf_edge_pulse_framer_tb;

    localparam int N_CH        = 3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_WAIT = 8;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [rfep_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [rfep_pkg::CFG_DATA_W-1:0]  cfg_data;

    rfep_edge_if  edge_ch ();
    rfep_pulse_if pulse_ch ();

    rf_edge_pulse_framer #(
        .CHANNELS (N_CH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .edges     (edge_ch),
        .pulses    (pulse_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predicted register and channel state
    bit [rfep_pkg::MASK_W-1:0] en_mask;
    bit [rfep_pkg::LEN_W-1:0]  start_min;
    bit [rfep_pkg::LEN_W-1:0]  start_max;
    bit [rfep_pkg::LEN_W-1:0]  period_min;
    bit [rfep_pkg::LEN_W-1:0]  period_max;
    bit [31:0]                 seen_time [N_CH];
    bit                        prev_lvl [N_CH];
    bit [31:0]                 filt [N_CH];
    bit                        glitch [N_CH];
    bit                        in_frame [N_CH];
    bit [rfep_pkg::LEN_W-1:0]  run_len [2];

    rfep_pkg::result_t pulse_due [$];

    // stimulus generator state
    bit [31:0] gen_time [N_CH];
    bit        gen_level [N_CH];

    bit feed_gaps;
    bit drain_stalls;
    int edges_counted;
    int mismatches;
    int unsigned cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("rf_edge_pulse_framer: mismatch");
            $finish;
        end
    end

    function automatic int frame_edge(input int c, input bit [31:0] t);
        bit [31:0] f;
        bit [15:0] d;
        int n;
        n = 0;
        if (t < seen_time[c])
        begin
            seen_time[c] = t;
            in_frame[c]  = 1'b0;
            return 0;
        end
        d = 16'(t - seen_time[c]);
        f = prev_lvl[c] ? filt[c] + {16'd0, d} : filt[c] - {16'd0, d};
        filt[c] = f;
        if (f != 0 && !f[31] && f < {16'd0, period_min})
        begin
            glitch[c] = 1'b1;
            return 0;
        end
        if (prev_lvl[c])
        begin
            d       = f[15:0];
            filt[c] = {16'd0, period_min};
        end
        else
        begin
            f       = {16'd0, period_min} - f;
            d       = f[15:0];
            filt[c] = 32'd0;
        end
        if (glitch[c])
        begin
            glitch[c] = 1'b0;
            return 0;
        end
        if (in_frame[c] && d > period_max)
        begin
            in_frame[c] = 1'b0;
            run_len[0]  = 16'd0;
            return 1;
        end
        if (d > start_max)
        begin
            in_frame[c] = 1'b0;
            return 0;
        end
        if (!in_frame[c] && d > start_min && d < start_max)
        begin
            in_frame[c] = 1'b1;
            run_len[n]  = 16'd0;
            n++;
        end
        run_len[n] = d;
        n++;
        seen_time[c] = t;
        return n;
    endfunction

    task automatic predict_edge(input bit [1:0] c, input bit [31:0] t, input bit lvl);
        int n;
        rfep_pkg::result_t r;
        if (c >= N_CH || !en_mask[c])
            return;
        edges_counted++;
        n = frame_edge(c, t);
        prev_lvl[c] = lvl;
        for (int i = 0; i < n; i++)
        begin
            r.channel = c;
            r.length  = run_len[i];
            r.last    = (i == n - 1);
            pulse_due.push_back(r);
        end
    endtask

    task automatic send_edge(input bit [1:0] c, input bit [31:0] t, input bit lvl);
        int gap;
        gap = feed_gaps ? $urandom_range(0, 17) : 0;
        if (gap > 0)
        begin
            edge_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        edge_ch.channel_id <= c;
        edge_ch.edge_time  <= t;
        edge_ch.line_level <= lvl;
        edge_ch.valid      <= 1'b1;
        do @(posedge clk); while (!edge_ch.ready);
        predict_edge(c, t, lvl);
    endtask

    task automatic settle();
        edge_ch.valid <= 1'b0;
        while (pulse_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input bit [rfep_pkg::CFG_INDEX_W-1:0] idx,
                             input bit [rfep_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            rfep_pkg::REG_ENABLE_MASK: en_mask    = data[rfep_pkg::MASK_W-1:0];
            rfep_pkg::REG_MIN_START:   start_min  = data;
            rfep_pkg::REG_MAX_START:   start_max  = data;
            rfep_pkg::REG_MIN_PERIOD:  period_min = data;
            rfep_pkg::REG_MAX_PERIOD:  period_max = data;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input bit [rfep_pkg::MASK_W-1:0] mask,
                                  input bit [rfep_pkg::LEN_W-1:0] smin,
                                  input bit [rfep_pkg::LEN_W-1:0] smax,
                                  input bit [rfep_pkg::LEN_W-1:0] pmin,
                                  input bit [rfep_pkg::LEN_W-1:0] pmax);
        bit [31:0] junk;
        junk = $urandom;
        settle();
        write_reg(rfep_pkg::REG_ENABLE_MASK,
                  {junk[rfep_pkg::CFG_DATA_W-rfep_pkg::MASK_W-1:0], mask});
        write_reg(rfep_pkg::REG_MIN_START, smin);
        write_reg(rfep_pkg::REG_MAX_START, smax);
        write_reg(rfep_pkg::REG_MIN_PERIOD, pmin);
        write_reg(rfep_pkg::REG_MAX_PERIOD, pmax);
        cfg_we <= 1'b0;
    endtask

    function automatic bit [31:0] pick_interval();
        int k;
        int v;
        k = $urandom_range(0, 99);
        if (k < 10)
            return $urandom_range(1, (period_min > 1) ? period_min - 1 : 1);
        if (k < 45)
            return $urandom_range(period_min, period_max);
        if (k < 65)
            return $urandom_range(start_min, start_max);
        if (k < 72)
            return $urandom_range(period_max, start_max);
        if (k < 78)
            return $urandom_range(start_max, 65535);
        if (k < 84)
        begin
            case ($urandom_range(0, 3))
                0: v = start_min;
                1: v = start_max;
                2: v = period_min;
                default: v = period_max;
            endcase
            v = v + int'($urandom_range(0, 2)) - 1;
            return (v < 0) ? 0 : v;
        end
        if (k < 90)
            return $urandom_range(65536, 200000);
        return $urandom_range(0, 65535);
    endfunction

    task automatic run_phase(input int target);
        int first;
        int iter;
        int k;
        bit [1:0] c;
        first = edges_counted;
        iter  = 0;
        for (int i = 0; i < N_CH; i++)
        begin
            gen_level[i] = prev_lvl[i];
            if ($urandom_range(0, 3) == 0)
                gen_time[i] = 32'hFFFF_FFFF - $urandom_range(0, 300000);
            else
                gen_time[i] = seen_time[i];
        end
        while (edges_counted - first < target)
        begin
            if (iter % 40 == 0)
            begin
                feed_gaps    = $urandom_range(0, 3) != 0;
                drain_stalls = $urandom_range(0, 3) != 0;
            end
            iter++;
            k = $urandom_range(0, 99);
            if (k < 87)
            begin
                do c = 2'($urandom_range(0, N_CH - 1)); while (!en_mask[c]);
                if (k < 82)
                    gen_level[c] = !gen_level[c];
                gen_time[c] = gen_time[c] + pick_interval();
                send_edge(c, gen_time[c], gen_level[c]);
            end
            else if (k < 91)
            begin
                c = 2'($urandom_range(0, N_CH - 1));
                gen_time[c]  = $urandom;
                gen_level[c] = !gen_level[c];
                send_edge(c, gen_time[c], gen_level[c]);
            end
            else if (k < 95)
                send_edge(rfep_pkg::CH_NO_MASK_BIT, $urandom, 1'($urandom_range(0, 1)));
            else
                send_edge(2'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_reset_state();
        send_edge(2'd0, 32'd5000, 1'b1);
        send_edge(rfep_pkg::CH_NO_MASK_BIT, 32'd7000, 1'b0);
        settle();
    endtask

    task automatic test_frame_cases();
        apply_settings(3'b011, rfep_pkg::RST_MIN_START, rfep_pkg::RST_MAX_START,
                       rfep_pkg::RST_MIN_PERIOD, rfep_pkg::RST_MAX_PERIOD);
        send_edge(2'd0, 32'd0, 1'b1);
        send_edge(2'd0, 32'd2000, 1'b0);
        send_edge(2'd0, 32'd2600, 1'b1);
        send_edge(2'd0, 32'd3300, 1'b0);
        // short spike then its end
        send_edge(2'd0, 32'd3400, 1'b1);
        send_edge(2'd0, 32'd3500, 1'b0);
        // long gap stops the frame, very long gap drops it silently
        send_edge(2'd0, 32'd9000, 1'b1);
        send_edge(2'd0, 32'd40000, 1'b0);
        // timestamp running backwards
        send_edge(2'd0, 32'd10, 1'b1);
        send_edge(2'd0, 32'hFFFF_FFFF, 1'b0);
        send_edge(2'd0, 32'hFFFF_FFFF, 1'b1);
        send_edge(2'd1, 32'd1500, 1'b1);
        send_edge(2'd1, 32'd1500, 1'b0);
        send_edge(2'd1, 32'd4200, 1'b1);
        send_edge(2'd2, 32'd100, 1'b1);
        send_edge(rfep_pkg::CH_NO_MASK_BIT, 32'd5, 1'b1);
        settle();
        write_reg(rfep_pkg::REG_ENABLE_MASK, 16'd0);
        cfg_we <= 1'b0;
        send_edge(2'd1, 32'd6000, 1'b0);
        settle();
    endtask

    task automatic test_unused_indexes();
        apply_settings(3'b111, rfep_pkg::RST_MIN_START, rfep_pkg::RST_MAX_START,
                       rfep_pkg::RST_MIN_PERIOD, rfep_pkg::RST_MAX_PERIOD);
        for (int i = rfep_pkg::REG_MAX_PERIOD + 1; i < 2 ** rfep_pkg::CFG_INDEX_W; i++)
            write_reg(i[rfep_pkg::CFG_INDEX_W-1:0], 16'hFFFF);
        cfg_we <= 1'b0;
        send_edge(2'd2, 32'd1000, 1'b1);
        send_edge(2'd2, 32'd3000, 1'b0);
        send_edge(2'd2, 32'd3900, 1'b1);
        settle();
    endtask

    task automatic test_random_traffic();
        apply_settings(3'b111, rfep_pkg::RST_MIN_START, rfep_pkg::RST_MAX_START,
                       rfep_pkg::RST_MIN_PERIOD, rfep_pkg::RST_MAX_PERIOD);
        run_phase(400);
        apply_settings(3'b111, 16'd0, 16'd0, 16'd0, 16'd0);
        run_phase(100);
        apply_settings(3'b111, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_phase(100);
        repeat (5)
        begin
            apply_settings(3'($urandom_range(1, 7)), 16'($urandom_range(0, 3000)),
                           16'($urandom_range(1000, 40000)), 16'($urandom_range(0, 2000)),
                           16'($urandom_range(500, 8000)));
            run_phase(230);
        end
    endtask

    initial
    begin
        int stall;
        pulse_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = drain_stalls ? $urandom_range(0, 17) : 0;
            if (stall > 0)
            begin
                pulse_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pulse_ch.ready <= 1'b1;
            do @(posedge clk); while (!(pulse_ch.valid && pulse_ch.ready));
        end
    end

    always @(posedge clk)
    begin
        rfep_pkg::result_t want;
        if (rst_n && pulse_ch.valid && pulse_ch.ready)
        begin
            if (pulse_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("pulse check: unexpected transaction ch=%0d len=%0d last=%0d",
                             pulse_ch.out_channel, pulse_ch.pulse_length, pulse_ch.last_of_run);
            end
            else
            begin
                want = pulse_due.pop_front();
                if (pulse_ch.out_channel !== want.channel || pulse_ch.pulse_length !== want.length
                    || pulse_ch.last_of_run !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pulse check: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                 want.channel, want.length, want.last, pulse_ch.out_channel,
                                 pulse_ch.pulse_length, pulse_ch.last_of_run);
                end
            end
        end
    end

    initial
    begin
        edge_ch.valid      <= 1'b0;
        edge_ch.channel_id <= '0;
        edge_ch.edge_time  <= '0;
        edge_ch.line_level <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= '0;
        rst_n              <= 1'b0;
        edges_counted = 0;
        en_mask    = rfep_pkg::RST_ENABLE_MASK;
        start_min  = rfep_pkg::RST_MIN_START;
        start_max  = rfep_pkg::RST_MAX_START;
        period_min = rfep_pkg::RST_MIN_PERIOD;
        period_max = rfep_pkg::RST_MAX_PERIOD;
        for (int i = 0; i < N_CH; i++)
        begin
            seen_time[i] = 32'd0;
            prev_lvl[i]  = 1'b0;
            filt[i]      = 32'd0;
            glitch[i]    = 1'b0;
            in_frame[i]  = 1'b0;
        end
        feed_gaps    = 1'b1;
        drain_stalls = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_frame_cases();
        test_unused_indexes();
        test_random_traffic();
        settle();
        if (mismatches == 0 && pulse_due.size() == 0)
            $display("rf_edge_pulse_framer: match");
        else
            $display("rf_edge_pulse_framer: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
design/rfep_pkg.sv
design/rfep_edge_if.sv
design/rfep_pulse_if.sv
design/rfep_cfg_regs.sv
design/rfep_chan_unit.sv
design/rfep_result_queue.sv
design/rf_edge_pulse_framer.sv
tb/sv/rf_edge_pulse_framer_tb.sv
